// ===== hw/rtl/gpr_pkg.sv =====
// ----------------------------------------------------------------------------
// gpr_pkg
// Shared types and constants for the GF(2) polynomial remainder block.
// ----------------------------------------------------------------------------
package gpr_pkg;

  localparam int unsigned GPR_FIELD_W = 32;
  localparam int unsigned GPR_IN_W    = 2 * GPR_FIELD_W;
  localparam int unsigned GPR_USER_W  = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NORM,
    ST_RED,
    ST_DONE
  } gpr_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic norm;
    logic red;
    logic done;
  } gpr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_zero;
    logic div_msb;
    logic cnt_zero;
    logic out_free;
  } gpr_stat_t;

endpackage

// ===== hw/rtl/gpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// gpr_ctrl
// Sequencer: load, normalise divisor, reduce remainder, hand over result.
// ----------------------------------------------------------------------------
module gpr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  gpr_pkg::gpr_stat_t stat,
  output gpr_pkg::gpr_cmd_t  cmd
);
  import gpr_pkg::*;

  gpr_state_t state_r;
  gpr_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_NORM;
      end
      ST_NORM: begin
        if (stat.div_zero) state_nxt = ST_DONE;
        else if (stat.div_msb) state_nxt = ST_RED;
      end
      ST_RED: begin
        if (stat.cnt_zero) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_NORM: begin
        cmd.norm = !stat.div_zero && !stat.div_msb;
      end
      ST_RED: begin
        cmd.red = 1'b1;
      end
      ST_DONE: begin
        cmd.done = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/gpr_datapath.sv =====
// ----------------------------------------------------------------------------
// gpr_datapath
// Remainder and divisor registers, bit-serial shift/XOR unit, output register.
// ----------------------------------------------------------------------------
module gpr_datapath #(
  parameter int unsigned POLY_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [gpr_pkg::GPR_FIELD_W-1:0]        dividend,
  input  logic [gpr_pkg::GPR_FIELD_W-1:0]        divisor,
  input  gpr_pkg::gpr_cmd_t                      cmd,
  output gpr_pkg::gpr_stat_t                     stat,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [gpr_pkg::GPR_FIELD_W-1:0]        remainder,
  output logic                                   divisible,
  output logic                                   zero_divisor
);
  import gpr_pkg::*;

  localparam int unsigned W  = POLY_WIDTH;
  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  rem_r;
  logic [W-1:0]  dsh_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] top_r;
  logic          divz_r;
  logic [W-1:0]  div_in;

  logic                   out_valid_r;
  logic [GPR_FIELD_W-1:0] out_rem_r;
  logic                   out_divisible_r;
  logic                   out_zd_r;

  assign div_in = W'(divisor);

  // normalise: shift divisor up until its top bit is set, counting shifts;
  // reduce: walk the aligned divisor back down, XORing where rem has the bit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r  <= W'(dividend);
      dsh_r  <= div_in;
      divz_r <= (div_in == '0);
      cnt_r  <= '0;
      top_r  <= CW'(W - 1);
    end else if (cmd.norm) begin
      dsh_r <= {dsh_r[W-2:0], 1'b0};
      cnt_r <= cnt_r + 1'b1;
    end else if (cmd.red) begin
      if (rem_r[top_r]) rem_r <= rem_r ^ dsh_r;
      dsh_r <= {1'b0, dsh_r[W-1:1]};
      cnt_r <= cnt_r - 1'b1;
      top_r <= top_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      out_rem_r       <= GPR_FIELD_W'(rem_r);
      out_divisible_r <= !divz_r && (rem_r == '0);
      out_zd_r        <= divz_r;
    end
  end

  assign stat.div_zero = divz_r;
  assign stat.div_msb  = dsh_r[W-1];
  assign stat.cnt_zero = (cnt_r == '0);
  assign stat.out_free = !out_valid_r || out_tready;

  assign out_tvalid   = out_valid_r;
  assign remainder    = out_rem_r;
  assign divisible    = out_divisible_r;
  assign zero_divisor = out_zd_r;

endmodule

// ===== hw/rtl/gf2_polynomial_remainder.sv =====
// ----------------------------------------------------------------------------
// gf2_polynomial_remainder
// Remainder of a polynomial division over GF(2), one bit position a cycle.
// ----------------------------------------------------------------------------
// Throughput: one request at a time; set by the single shift/XOR unit, which
//   first normalises the divisor and then reduces, one bit per cycle each.
// A result waits in the output register while the next request is taken.
// Reset: synchronous, active low; clears sequencer and output valid only.
module gf2_polynomial_remainder #(
  parameter int unsigned POLY_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [gpr_pkg::GPR_IN_W-1:0]     in_tdata,   // dividend[31:0], divisor[63:32]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [gpr_pkg::GPR_FIELD_W-1:0]  out_tdata,  // remainder[31:0]
  output logic [gpr_pkg::GPR_USER_W-1:0]   out_tuser   // divisible[0], zero_divisor[1]
);
  import gpr_pkg::*;

  gpr_cmd_t  cmd;
  gpr_stat_t stat;
  logic      divisible;
  logic      zero_divisor;

  gpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gpr_datapath #(
    .POLY_WIDTH (POLY_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .dividend     (in_tdata[GPR_FIELD_W-1:0]),
    .divisor      (in_tdata[GPR_IN_W-1:GPR_FIELD_W]),
    .cmd          (cmd),
    .stat         (stat),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .remainder    (out_tdata),
    .divisible    (divisible),
    .zero_divisor (zero_divisor)
  );

  assign out_tuser = {zero_divisor, divisible};

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(divisible && zero_divisor))
    else $error("divisible and zero_divisor both set");

  a_div_rem_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && divisible) |-> (out_tdata == '0))
    else $error("divisible with nonzero remainder");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second request taken while busy");

  a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.done |-> (!out_tvalid || out_tready))
    else $error("result overwritten before taken");

endmodule

// ===== tb/sv/gf2_polynomial_remainder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2_polynomial_remainder_tb
// Self-checking bench: directed table, then random requests in three phases,
// the last with no idling. Each result is compared per field, in request order,
// against the typed table values or an in-bench GF(2) long-division predictor.
// ----------------------------------------------------------------------------
module gf2_polynomial_remainder_tb;
  import gpr_pkg::*;

  localparam int unsigned W            = GPR_FIELD_W;
  localparam int unsigned DIVISIBLE_B  = 0;
  localparam int unsigned ZERO_DIV_B   = 1;
  localparam int unsigned N_PER_PHASE  = 400;
  localparam int unsigned DRAIN_CYCLES = 2 * W + 8;

  typedef struct packed {
    logic [W-1:0] rem;
    logic         divisible;
    logic         zero_div;
  } remainder_t;

  typedef struct packed {
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
    logic         typed;
    logic [W-1:0] rem;
    logic         divisible;
    logic         zero_div;
  } dir_row_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [GPR_IN_W-1:0] in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [W-1:0]        out_tdata;
  logic [GPR_USER_W-1:0] out_tuser;

  int unsigned valid_idle_pct = 37;
  int unsigned ready_idle_pct = 64;
  int unsigned mismatches     = 0;
  remainder_t  rem_expected_q[$];

  // typed rows: zero divisor, zero dividend, unit divisor, exact multiples,
  // dividend below divisor degree; the rest go through the predictor
  dir_row_t dir_rows [20] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 1'b1},
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b1},
    '{32'h0000_0000, 32'h0000_0001, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
    '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
    '{32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
    '{32'h0000_0001, 32'h8000_0000, 1'b1, 32'h0000_0001, 1'b0, 1'b0},
    '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0},
    '{32'h0000_0003, 32'h0000_0003, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
    '{32'h0000_0001, 32'h0000_0002, 1'b1, 32'h0000_0001, 1'b0, 1'b0},
    '{32'hC000_0000, 32'h4000_0000, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
    '{32'h8000_0000, 32'h0000_0003, 1'b0, '0, 1'b0, 1'b0},
    '{32'h1234_5678, 32'h0000_011B, 1'b0, '0, 1'b0, 1'b0},
    '{32'hDEAD_BEEF, 32'h04C1_1DB7, 1'b0, '0, 1'b0, 1'b0},
    '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0, 1'b0, 1'b0},
    '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0, 1'b0, 1'b0},
    '{32'hFFFF_0000, 32'h0001_0001, 1'b0, '0, 1'b0, 1'b0},
    '{32'h8000_0001, 32'h0000_0002, 1'b0, '0, 1'b0, 1'b0},
    '{32'h0000_0002, 32'h0000_0003, 1'b0, '0, 1'b0, 1'b0}
  };

  gf2_polynomial_remainder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  function automatic int unsigned lead_degree(logic [W-1:0] p);
    int unsigned d;
    d = 0;
    for (int unsigned i = 0; i < W; i++) begin
      if (p[i]) d = i;
    end
    return d;
  endfunction

  function automatic remainder_t gf2_remainder(logic [W-1:0] dividend,
                                               logic [W-1:0] divisor);
    remainder_t   r;
    logic [W-1:0] acc;
    int unsigned  dd;
    int unsigned  rd;
    acc = dividend;
    r   = '0;
    if (divisor == '0) begin
      r.zero_div = 1'b1;
    end else begin
      dd = lead_degree(divisor);
      while (acc != '0) begin
        rd = lead_degree(acc);
        if (rd < dd) break;
        acc ^= divisor << (rd - dd);
      end
      r.divisible = (acc == '0);
    end
    r.rem = acc;
    return r;
  endfunction

  function automatic logic [W-1:0] clmul(logic [W-1:0] a, logic [W-1:0] b);
    logic [W-1:0] p;
    p = '0;
    for (int unsigned i = 0; i < W; i++) begin
      if (b[i]) p ^= a << i;
    end
    return p;
  endfunction

  function automatic logic [W-1:0] rand_divisor();
    logic [W-1:0] d;
    int unsigned  deg;
    case ($urandom_range(15))
      0: return '0;
      1: return 1;
      2: return $urandom();
      default: begin
        deg    = $urandom_range(W - 1);
        d      = $urandom() & ({W{1'b1}} >> (W - 1 - deg));
        d[deg] = 1'b1;
        return d;
      end
    endcase
  endfunction

  function automatic logic [W-1:0] rand_dividend(logic [W-1:0] divisor);
    int unsigned qdeg;
    case ($urandom_range(15))
      0: return '0;
      1, 2, 3, 4: begin
        if (divisor == '0) return $urandom();
        qdeg = W - 1 - lead_degree(divisor);
        return clmul(divisor, $urandom() & ({W{1'b1}} >> (W - 1 - qdeg)));
      end
      5, 6: return $urandom() >> $urandom_range(W - 1);
      default: return $urandom();
    endcase
  endfunction

  task automatic push_request(logic [W-1:0] dividend, logic [W-1:0] divisor,
                              logic typed, remainder_t typed_res);
    remainder_t exp_item;
    while ($urandom_range(99) < valid_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {divisor, dividend};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    exp_item       = typed ? typed_res : gf2_remainder(dividend, divisor);
    rem_expected_q = {rem_expected_q, exp_item};
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= ready_idle_pct);
  end

  always @(posedge clk) begin
    remainder_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (rem_expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual rem %h user %b",
                 $time, out_tdata, out_tuser);
        mismatches++;
      end else begin
        exp_r = rem_expected_q.pop_front();
        if (out_tdata !== exp_r.rem) begin
          $display("%0t: remainder expected %h, actual %h", $time, exp_r.rem, out_tdata);
          mismatches++;
        end
        if (out_tuser[DIVISIBLE_B] !== exp_r.divisible) begin
          $display("%0t: divisible expected %b, actual %b", $time, exp_r.divisible,
                   out_tuser[DIVISIBLE_B]);
          mismatches++;
        end
        if (out_tuser[ZERO_DIV_B] !== exp_r.zero_div) begin
          $display("%0t: zero_divisor expected %b, actual %b", $time, exp_r.zero_div,
                   out_tuser[ZERO_DIV_B]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [W-1:0] dvs;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      push_request(dir_rows[i].dividend, dir_rows[i].divisor, dir_rows[i].typed,
                   '{dir_rows[i].rem, dir_rows[i].divisible, dir_rows[i].zero_div});
    end

    for (int ph = 0; ph < 3; ph++) begin
      valid_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 64 : 0;
      ready_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 37 : 0;
      for (int unsigned n = 0; n < N_PER_PHASE; n++) begin
        dvs = rand_divisor();
        push_request(rand_dividend(dvs), dvs, 1'b0, '0);
      end
    end
    in_tvalid <= 1'b0;

    while (rem_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
